// ----- hdl/eef_pkg.sv -----
// ---------------------------------------------------------------------------
// eef_pkg
// Shared types, constants and helpers of the EMG envelope filter: word
// formats, history row layout, sequencer states and fixed-point coefficients.
// ---------------------------------------------------------------------------
package eef_pkg;

  // sizes
  localparam int CHANNELS     = 8;
  localparam int HISTORY_BITS = 32;
  localparam int CH_W         = 3;
  localparam int SAMPLE_W     = 16;
  localparam int LIMIT_W      = 15;
  localparam int Q_SHIFT      = 12;                  // Q4.12 to Q8.24
  localparam int COEF_W       = 32;                  // Q2.30
  localparam int COEF_FRAC    = 30;
  localparam int S_W          = HISTORY_BITS + 2;    // x0 +- 2*x1 + x2
  localparam int LO_W         = S_W / 2;
  localparam int HI_W         = S_W - LO_W;
  localparam int MUL_W        = LO_W + 1;
  localparam int PROD_W       = MUL_W + COEF_W;
  localparam int PACC_W       = S_W + COEF_W;
  localparam int ACC_W        = HISTORY_BITS + 8;
  localparam int ROWS         = 3 * CHANNELS;
  localparam int ROW_W        = $clog2(ROWS);
  localparam int CFG_IDX_W    = 2;

  // configuration registers
  localparam logic [CFG_IDX_W-1:0] REG_ARTEFACT_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR    = CFG_IDX_W'(1);
  localparam logic [LIMIT_W-1:0]   ARTEFACT_RESET     = LIMIT_W'(2048);
  localparam logic [LIMIT_W-1:0]   NOISE_RESET        = LIMIT_W'(82);

  // words
  typedef struct packed {
    logic [CH_W-1:0]            channel;
    logic signed [SAMPLE_W-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic [CH_W-1:0]            out_channel;
    logic signed [SAMPLE_W-1:0] envelope;
  } out_word_t;

  // one history row: one filter of one channel
  typedef struct packed {
    logic signed [HISTORY_BITS-1:0] x1;
    logic signed [HISTORY_BITS-1:0] x2;
    logic signed [HISTORY_BITS-1:0] y1;
    logic signed [HISTORY_BITS-1:0] y2;
  } hist_row_t;

  typedef enum logic [1:0] {
    FLT_HIGHPASS,
    FLT_BANDLIMIT,
    FLT_ENVELOPE
  } filter_e;

  typedef enum logic [1:0] {
    TERM_INPUT,
    TERM_Y1,
    TERM_Y2
  } term_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ACC,
    ST_WRITE,
    ST_GATE,
    ST_FIN
  } state_e;

  // multiply-accumulate controls
  typedef struct packed {
    logic clr_y;
    logic mul_lo;
    logic mul_hi;
    logic acc;
    logic sub;
  } mac_ctrl_t;

  // coefficient magnitudes, round half up of v * 2^30
  localparam logic [127:0] D15 = 128'd1000000000000000;
  localparam logic [127:0] D18 = 128'd1000000000000000000;
  localparam logic [127:0] Q_HP_A1 = (((128'd1783787708559230 << 31) / D15) + 128'd1) >> 1;
  localparam logic [127:0] Q_HP_A2 = (((128'd804982594421399 << 31) / D15) + 128'd1) >> 1;
  localparam logic [127:0] Q_HP_K  = (((128'd897192575745157 << 31) / D15) + 128'd1) >> 1;
  localparam logic [127:0] Q_BL_A1 = (((128'd43134450881076 << 31) / D15) + 128'd1) >> 1;
  localparam logic [127:0] Q_BL_A2 = (((128'd171901801714236 << 31) / D15) + 128'd1) >> 1;
  localparam logic [127:0] Q_BL_K  = (((128'd282191837708290 << 31) / D15) + 128'd1) >> 1;
  localparam logic [127:0] Q_EN_A1 = (((128'd1991322548359169 << 31) / D15) + 128'd1) >> 1;
  localparam logic [127:0] Q_EN_A2 = (((128'd991360035149071 << 31) / D15) + 128'd1) >> 1;
  localparam logic [127:0] Q_EN_K  = (((128'd9371697475252 << 31) / D18) + 128'd1) >> 1;

  localparam logic signed [COEF_W-1:0] C_HP_A1 = -$signed(Q_HP_A1[COEF_W-1:0]);
  localparam logic signed [COEF_W-1:0] C_HP_A2 = $signed(Q_HP_A2[COEF_W-1:0]);
  localparam logic signed [COEF_W-1:0] C_HP_K  = $signed(Q_HP_K[COEF_W-1:0]);
  localparam logic signed [COEF_W-1:0] C_BL_A1 = -$signed(Q_BL_A1[COEF_W-1:0]);
  localparam logic signed [COEF_W-1:0] C_BL_A2 = $signed(Q_BL_A2[COEF_W-1:0]);
  localparam logic signed [COEF_W-1:0] C_BL_K  = $signed(Q_BL_K[COEF_W-1:0]);
  localparam logic signed [COEF_W-1:0] C_EN_A1 = -$signed(Q_EN_A1[COEF_W-1:0]);
  localparam logic signed [COEF_W-1:0] C_EN_A2 = $signed(Q_EN_A2[COEF_W-1:0]);
  localparam logic signed [COEF_W-1:0] C_EN_K  = $signed(Q_EN_K[COEF_W-1:0]);

  // coefficient for a filter and a product term
  function automatic logic signed [COEF_W-1:0] coef_lookup(input filter_e f, input term_e t);
    logic signed [COEF_W-1:0] c;
    c = '0;
    case (f)
      FLT_HIGHPASS: begin
        case (t)
          TERM_INPUT: c = C_HP_K;
          TERM_Y1:    c = C_HP_A1;
          TERM_Y2:    c = C_HP_A2;
          default:    c = '0;
        endcase
      end
      FLT_BANDLIMIT: begin
        case (t)
          TERM_INPUT: c = C_BL_K;
          TERM_Y1:    c = C_BL_A1;
          TERM_Y2:    c = C_BL_A2;
          default:    c = '0;
        endcase
      end
      FLT_ENVELOPE: begin
        case (t)
          TERM_INPUT: c = C_EN_K;
          TERM_Y1:    c = C_EN_A1;
          TERM_Y2:    c = C_EN_A2;
          default:    c = '0;
        endcase
      end
      default: c = '0;
    endcase
    return c;
  endfunction

  // saturate to history width
  function automatic logic signed [HISTORY_BITS-1:0] sat_hist(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi_lim;
    logic signed [ACC_W-1:0] lo_lim;
    logic signed [HISTORY_BITS-1:0] r;
    hi_lim = $signed({{(ACC_W-HISTORY_BITS+1){1'b0}}, {(HISTORY_BITS-1){1'b1}}});
    lo_lim = ~hi_lim;
    if (v > hi_lim) begin
      r = hi_lim[HISTORY_BITS-1:0];
    end else if (v < lo_lim) begin
      r = lo_lim[HISTORY_BITS-1:0];
    end else begin
      r = v[HISTORY_BITS-1:0];
    end
    return r;
  endfunction

  // Q8.24 to Q4.12, round half up, saturated
  function automatic logic signed [SAMPLE_W-1:0] round_env(input logic signed [HISTORY_BITS-1:0] y);
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-1:0] hi_lim;
    logic signed [ACC_W-1:0] lo_lim;
    logic signed [SAMPLE_W-1:0] r;
    hi_lim = ACC_W'(32767);
    lo_lim = -ACC_W'(32768);
    t = (ACC_W'(y) + ACC_W'(2048)) >>> Q_SHIFT;
    if (t > hi_lim) begin
      r = hi_lim[SAMPLE_W-1:0];
    end else if (t < lo_lim) begin
      r = lo_lim[SAMPLE_W-1:0];
    end else begin
      r = t[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/eef_mac.sv -----
// ---------------------------------------------------------------------------
// eef_mac
// Shared multiply-accumulate unit: one 18x32 signed multiplier used twice per
// product (low then high half of the operand), per-product rounding to Q8.24
// and a signed accumulator for the biquad output.
// ---------------------------------------------------------------------------
module eef_mac (
  input  logic                              clk_i,
  input  eef_pkg::mac_ctrl_t                ctrl_i,
  input  logic signed [eef_pkg::S_W-1:0]    opnd_i,
  input  logic signed [eef_pkg::COEF_W-1:0] coef_i,
  output logic signed [eef_pkg::ACC_W-1:0]  acc_o
);
  import eef_pkg::*;

  logic signed [HI_W-1:0]   hi_s;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [PROD_W-1:0] prod;
  logic signed [PACC_W-1:0] pacc_q, pacc_d;
  logic signed [PACC_W-1:0] rsum;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  y_q, y_d;

  // operand half select and multiplier
  assign hi_s  = $signed(opnd_i[S_W-1:LO_W]);
  assign mul_a = ctrl_i.mul_hi ? MUL_W'(hi_s) : $signed({1'b0, opnd_i[LO_W-1:0]});
  assign prod  = PROD_W'(mul_a) * PROD_W'(coef_i);

  // product assembly
  always_comb begin
    pacc_d = pacc_q;
    if (ctrl_i.mul_lo) begin
      pacc_d = PACC_W'(prod);
    end else if (ctrl_i.mul_hi) begin
      pacc_d = pacc_q + (PACC_W'(prod) <<< LO_W);
    end
  end

  // round half up to Q8.24
  assign rsum = pacc_q + (PACC_W'(1) <<< (COEF_FRAC - 1));
  assign rnd  = ACC_W'($signed(rsum[PACC_W-1:COEF_FRAC]));

  // output accumulator
  always_comb begin
    y_d = y_q;
    if (ctrl_i.clr_y) begin
      y_d = '0;
    end else if (ctrl_i.acc) begin
      y_d = ctrl_i.sub ? (y_q - rnd) : (y_q + rnd);
    end
  end

  always_ff @(posedge clk_i) begin
    pacc_q <= pacc_d;
    y_q    <= y_d;
  end

  assign acc_o = y_q;

endmodule

// ----- hdl/emg_envelope_filter_unit.sv -----
// ---------------------------------------------------------------------------
// emg_envelope_filter_unit
// EMG linear envelope: high-pass, band-limit low-pass, artefact and noise
// gating, rectification and envelope low-pass, with per-channel history.
// ---------------------------------------------------------------------------
// Sequencing: a new input word is accepted only in the idle state, after the
//   result of the last one is loaded; nine products each take two passes
//   through the one shared 18x32 multiplier, plus row read/write steps.
// Reset: history rows read as zero until first written (per-row valid bits,
//   no clearing pass); limits return to 2048 and 82.
// ---------------------------------------------------------------------------
module emg_envelope_filter_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  eef_pkg::in_word_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output eef_pkg::out_word_t                out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [eef_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [eef_pkg::LIMIT_W-1:0]       cfg_data_i
);
  import eef_pkg::*;

  state_e    state_q, state_d;
  filter_e   flt_q, flt_d;
  term_e     term_q, term_d;
  logic [CH_W-1:0] ch_q, ch_d;
  logic signed [HISTORY_BITS-1:0] x0_q, x0_d;
  logic signed [S_W-1:0] opnd_q, opnd_d;
  hist_row_t rd_q;
  hist_row_t wr_row;
  logic      mem_we;
  logic [ROW_W-1:0] row_addr;
  logic [ROWS-1:0]  valid_q;
  hist_row_t mem [ROWS];
  logic [LIMIT_W-1:0] art_q, nfl_q;
  out_word_t out_q, out_d;
  logic      out_valid_q, out_load;
  mac_ctrl_t mac_ctrl;
  logic signed [ACC_W-1:0] acc;
  logic signed [HISTORY_BITS-1:0] y_sat;
  logic signed [S_W-1:0] x0_e, x1_e, x2_e;
  logic signed [ACC_W-1:0] mag;
  logic signed [ACC_W-1:0] art_lim, nfl_lim;
  logic signed [HISTORY_BITS-1:0] gated;

  // shared multiply-accumulate
  eef_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .opnd_i (opnd_q),
    .coef_i (coef_lookup(flt_q, term_q)),
    .acc_o  (acc)
  );

  assign row_addr = ROW_W'(int'(flt_q) * CHANNELS + int'(ch_q));
  assign y_sat    = sat_hist(acc);

  // history update for the filter just finished
  always_comb begin
    wr_row.x1 = x0_q;
    wr_row.x2 = rd_q.x1;
    wr_row.y1 = y_sat;
    wr_row.y2 = rd_q.y1;
  end

  // biquad input sum terms
  assign x0_e = S_W'(x0_q);
  assign x1_e = S_W'(rd_q.x1) <<< 1;
  assign x2_e = S_W'(rd_q.x2);

  // rectify, then artefact and noise gating on the magnitude
  assign mag     = x0_q[HISTORY_BITS-1] ? -ACC_W'(x0_q) : ACC_W'(x0_q);
  assign art_lim = $signed(ACC_W'({art_q, {Q_SHIFT{1'b0}}}));
  assign nfl_lim = $signed(ACC_W'({nfl_q, {Q_SHIFT{1'b0}}}));
  assign gated   = ((mag > art_lim) || (mag < nfl_lim)) ? '0 : sat_hist(mag);

  // sequencer
  always_comb begin
    state_d  = state_q;
    flt_d    = flt_q;
    term_d   = term_q;
    ch_d     = ch_q;
    x0_d     = x0_q;
    opnd_d   = opnd_q;
    out_d    = out_q;
    out_load = 1'b0;
    mem_we   = 1'b0;
    mac_ctrl = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && (int'(in_data_i.channel) < CHANNELS)) begin
          ch_d    = in_data_i.channel;
          x0_d    = sat_hist(ACC_W'(in_data_i.sample) <<< Q_SHIFT);
          flt_d   = FLT_HIGHPASS;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        term_d  = TERM_INPUT;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        case (term_q)
          TERM_INPUT: begin
            opnd_d = (flt_q == FLT_HIGHPASS) ? (x0_e - x1_e + x2_e) : (x0_e + x1_e + x2_e);
            mac_ctrl.clr_y = 1'b1;
          end
          TERM_Y1: opnd_d = S_W'(rd_q.y1);
          TERM_Y2: opnd_d = S_W'(rd_q.y2);
          default: opnd_d = '0;
        endcase
        state_d = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        mac_ctrl.mul_lo = 1'b1;
        state_d = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        mac_ctrl.mul_hi = 1'b1;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        mac_ctrl.acc = 1'b1;
        mac_ctrl.sub = (term_q != TERM_INPUT);
        case (term_q)
          TERM_INPUT: begin
            term_d  = TERM_Y1;
            state_d = ST_LOAD;
          end
          TERM_Y1: begin
            term_d  = TERM_Y2;
            state_d = ST_LOAD;
          end
          default: state_d = ST_WRITE;
        endcase
      end
      ST_WRITE: begin
        mem_we = 1'b1;
        x0_d   = y_sat;
        case (flt_q)
          FLT_HIGHPASS: begin
            flt_d   = FLT_BANDLIMIT;
            state_d = ST_READ;
          end
          FLT_BANDLIMIT: state_d = ST_GATE;
          default:       state_d = ST_FIN;
        endcase
      end
      ST_GATE: begin
        x0_d    = gated;
        flt_d   = FLT_ENVELOPE;
        state_d = ST_READ;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_load          = 1'b1;
          out_d.out_channel = ch_q;
          out_d.envelope    = round_env(x0_q);
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      flt_q       <= FLT_HIGHPASS;
      term_q      <= TERM_INPUT;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      art_q       <= ARTEFACT_RESET;
      nfl_q       <= NOISE_RESET;
    end else begin
      state_q <= state_d;
      flt_q   <= flt_d;
      term_q  <= term_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (mem_we) begin
        valid_q[row_addr] <= 1'b1;
      end
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_ARTEFACT_LIMIT) begin
          art_q <= cfg_data_i;
        end else if (cfg_index_i == REG_NOISE_FLOOR) begin
          nfl_q <= cfg_data_i;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    x0_q   <= x0_d;
    opnd_q <= opnd_d;
    out_q  <= out_d;
  end

  // history memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[row_addr] <= wr_row;
    end
    if (state_q == ST_READ) begin
      rd_q <= valid_q[row_addr] ? mem[row_addr] : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // checks
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FIN)
    else $error("result word raised outside the final step");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_READ || state_q == ST_IDLE))
    else $error("accepted word did not start a history read");

  a_write_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |-> ($past(state_q) == ST_ACC && $past(term_q) == TERM_Y2))
    else $error("history written before all three products");

  a_gate_after_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GATE) |-> (flt_q == FLT_BANDLIMIT))
    else $error("gating outside the band-limit filter");

endmodule
